@@ design/smpf_pkg.sv @@
// ============================================================================
// smpf_pkg: shared types for the scan minimum parabolic fit
// Word and wide-word types, request and result structs, the job that the
// front hands to the back, and the state encodings of the sequencers.
// ============================================================================
`default_nettype none

package smpf_pkg;

  localparam int WORD_BITS = 32;
  // Wide enough for every intermediate product of the fit without wrap.
  localparam int BIG_BITS  = 8 * WORD_BITS + 8;
  localparam int QUO_BITS  = WORD_BITS + 2;
  localparam int QS_BITS   = WORD_BITS + 3;
  localparam int SUM_BITS  = WORD_BITS + 4;
  localparam int CNT_BITS  = $clog2(QUO_BITS);

  typedef logic signed [WORD_BITS-1:0] word_t;
  typedef logic signed [BIG_BITS-1:0]  big_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_FEW_ROWS   = 3'd1,
    ST_RISES      = 3'd2,
    ST_NO_MIN     = 3'd3,
    ST_DEGENERATE = 3'd4
  } status_t;

  typedef struct packed {
    word_t position;
    word_t energy;
    word_t density;
    word_t vacancy;
    logic  last;
  } row_in_t;

  typedef struct packed {
    word_t   energy_at_min;
    word_t   density_at_min;
    word_t   vacancy_at_min;
    status_t status;
  } fit_out_t;

  // Slot 0 is the oldest row.
  typedef struct packed {
    word_t [2:0] pos;
    word_t [2:0] en;
    word_t [2:0] den;
    word_t [2:0] vac;
  } window_t;

  typedef struct packed {
    logic    do_fit;
    logic    do_out;
    logic    use_fit;
    status_t status;
    window_t win;
  } job_t;

  typedef enum logic [3:0] {
    BK_IDLE, BK_GEOM, BK_COL, BK_MUL_GO, BK_MUL_WAIT,
    BK_CHECK, BK_DIV_GO, BK_DIV_WAIT, BK_EMIT
  } back_state_t;

  typedef enum logic [3:0] {
    FS_T, FS_DD, FS_D1S, FS_D3S, FS_A, FS_B, FS_C, FS_D,
    FS_N, FS_M, FS_PP, FS_M2, FS_S1, FS_S2, FS_SN
  } fit_step_t;

  typedef enum logic [1:0] {
    COL_ENERGY, COL_DENSITY, COL_VACANCY
  } column_t;

  typedef enum logic [1:0] {
    MUL_IDLE, MUL_RUN, MUL_FIN
  } mul_state_t;

  typedef enum logic [3:0] {
    DIV_IDLE, DIV_SIGN, DIV_ABS, DIV_CHK, DIV_ITER,
    DIV_REM, DIV_FIX, DIV_SUM, DIV_SAT
  } div_state_t;

  function automatic big_t widen(word_t v);
    return {{(BIG_BITS - WORD_BITS){v[WORD_BITS-1]}}, v};
  endfunction

endpackage

`default_nettype wire

@@ design/smpf_front.sv @@
// ============================================================================
// smpf_front: row window and minimum search
// Slides the three-row window, detects the stop row and the scan end, and
// queues fit and result jobs for the back end.
// ============================================================================
`default_nettype none

module smpf_front import smpf_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  row_in_t in_row,
  input  logic    queue_full,
  output logic    push,
  output job_t    push_job
);

  window_t    win_r, win_nxt;
  logic [1:0] rows_r, rows_nxt, rows_inc;
  logic       stopped_r, stopped_nxt;
  logic       rise_r, rise_nxt;
  logic       rise, stop, accept;

  assign in_ready = !queue_full;
  assign accept   = in_valid && in_ready;
  assign rows_inc = (rows_r == 2'd3) ? rows_r : rows_r + 2'd1;

  always_comb begin
    win_nxt = win_r;
    rise    = 1'b0;
    stop    = 1'b0;
    if (!stopped_r) begin
      win_nxt.pos = {in_row.position, win_r.pos[2], win_r.pos[1]};
      win_nxt.en  = {in_row.energy,   win_r.en[2],  win_r.en[1]};
      win_nxt.den = {in_row.density,  win_r.den[2], win_r.den[1]};
      win_nxt.vac = {in_row.vacancy,  win_r.vac[2], win_r.vac[1]};
      rise = (rows_inc == 2'd2) && ($signed(win_r.en[2]) < $signed(in_row.energy));
      stop = (rows_inc == 2'd3) && !($signed(in_row.energy) < $signed(win_r.en[2]));
    end
    rows_nxt    = rows_inc;
    stopped_nxt = stopped_r || rise || stop;
    rise_nxt    = rise_r || rise;
  end

  always_comb begin
    push_job         = '0;
    push_job.do_fit  = stop;
    push_job.do_out  = in_row.last;
    push_job.win     = win_nxt;
    push_job.use_fit = 1'b0;
    priority if (rows_nxt != 2'd3) begin
      push_job.status = ST_FEW_ROWS;
    end else if (!stopped_nxt) begin
      push_job.status = ST_NO_MIN;
    end else if (rise_nxt) begin
      push_job.status = ST_RISES;
    end else begin
      push_job.status  = ST_OK;
      push_job.use_fit = 1'b1;
    end
  end

  assign push = accept && (stop || in_row.last);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r    <= 2'd0;
      stopped_r <= 1'b0;
      rise_r    <= 1'b0;
    end else if (accept) begin
      if (in_row.last) begin
        rows_r    <= 2'd0;
        stopped_r <= 1'b0;
        rise_r    <= 1'b0;
      end else begin
        rows_r    <= rows_nxt;
        stopped_r <= stopped_nxt;
        rise_r    <= rise_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      win_r <= win_nxt;
    end
  end

endmodule

`default_nettype wire

@@ design/smpf_queue.sv @@
// ============================================================================
// smpf_queue: job queue between front and back
// A small first-in first-out buffer of jobs with a combinational head.
// ============================================================================
`default_nettype none

module smpf_queue import smpf_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output job_t head
);

  localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W    = $clog2(DEPTH + 1);

  job_t                mem_r [DEPTH];
  logic [PTR_BITS-1:0] wr_r, rd_r;
  logic [CNT_W-1:0]    cnt_r;

  function automatic logic [PTR_BITS-1:0] bump(logic [PTR_BITS-1:0] p);
    return (p == PTR_BITS'(DEPTH - 1)) ? '0 : p + PTR_BITS'(1);
  endfunction

  assign full       = (cnt_r == CNT_W'(DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head       = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_r <= bump(wr_r);
      end
      if (pop) begin
        rd_r <= bump(rd_r);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_job;
    end
  end

endmodule

`default_nettype wire

@@ design/smpf_mul.sv @@
// ============================================================================
// smpf_mul: shift-add wide multiplier
// Signed product of two wide words, one multiplier bit per cycle, stopping
// as soon as the remaining multiplier bits are all zero.
// ============================================================================
`default_nettype none

module smpf_mul import smpf_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  big_t op_a,
  input  big_t op_b,
  output logic done,
  output big_t product
);

  mul_state_t state_r, state_nxt;
  big_t       acc_r, ma_r, mb_r;
  logic       sgn_r, done_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      MUL_IDLE: if (start) state_nxt = MUL_RUN;
      MUL_RUN:  if (mb_r == '0) state_nxt = MUL_FIN;
      MUL_FIN:  state_nxt = MUL_IDLE;
      default:  state_nxt = MUL_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= MUL_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= (state_r == MUL_FIN);
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      MUL_IDLE: begin
        if (start) begin
          acc_r <= '0;
          ma_r  <= op_a[BIG_BITS-1] ? -op_a : op_a;
          mb_r  <= op_b[BIG_BITS-1] ? -op_b : op_b;
          sgn_r <= op_a[BIG_BITS-1] ^ op_b[BIG_BITS-1];
        end
      end
      MUL_RUN: begin
        if (mb_r != '0) begin
          if (mb_r[0]) begin
            acc_r <= acc_r + ma_r;
          end
          ma_r <= ma_r << 1;
          mb_r <= mb_r >> 1;
        end
      end
      MUL_FIN: acc_r <= sgn_r ? -acc_r : acc_r;
      default: ;
    endcase
  end

  assign done    = done_r;
  assign product = acc_r;

endmodule

`default_nettype wire

@@ design/smpf_div.sv @@
// ============================================================================
// smpf_div: restoring divider with offset, truncation and saturation
// Returns base + num/den truncated toward zero and saturated to a word,
// one quotient bit per cycle.
// ============================================================================
`default_nettype none

module smpf_div import smpf_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  start,
  input  word_t base,
  input  big_t  num,
  input  big_t  den,
  output logic  done,
  output word_t result
);

  localparam logic signed [SUM_BITS-1:0] SAT_HI =
    {{(SUM_BITS - WORD_BITS + 1){1'b0}}, {(WORD_BITS - 1){1'b1}}};
  localparam logic signed [SUM_BITS-1:0] SAT_LO =
    {{(SUM_BITS - WORD_BITS + 1){1'b1}}, {(WORD_BITS - 1){1'b0}}};

  div_state_t                  state_r, state_nxt;
  word_t                       base_r, res_r;
  big_t                        n_r, m_r, a_r, ms_r;
  logic [QUO_BITS-1:0]         q_r;
  logic [CNT_BITS-1:0]         i_r;
  logic                        nneg_r, rem_r, done_r, ovf;
  logic signed [QS_BITS-1:0]   qs_r, qext;
  logic signed [SUM_BITS-1:0]  sum_r, adj;

  assign ovf  = $unsigned(a_r) >= $unsigned(m_r << (WORD_BITS + 1));
  assign qext = {1'b0, q_r};
  assign adj  = sum_r + SUM_BITS'(sum_r[SUM_BITS-1] && rem_r);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      DIV_IDLE: if (start) state_nxt = DIV_SIGN;
      DIV_SIGN: state_nxt = DIV_ABS;
      DIV_ABS:  state_nxt = DIV_CHK;
      DIV_CHK:  state_nxt = ovf ? DIV_FIX : DIV_ITER;
      DIV_ITER: if (i_r == '0) state_nxt = DIV_REM;
      DIV_REM:  state_nxt = DIV_FIX;
      DIV_FIX:  state_nxt = DIV_SUM;
      DIV_SUM:  state_nxt = DIV_SAT;
      DIV_SAT:  state_nxt = DIV_IDLE;
      default:  state_nxt = DIV_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= DIV_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= (state_r == DIV_SAT);
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      DIV_IDLE: begin
        if (start) begin
          base_r <= base;
          n_r    <= num;
          m_r    <= den;
        end
      end
      DIV_SIGN: begin
        // Make the divisor positive.
        if (m_r[BIG_BITS-1]) begin
          m_r <= -m_r;
          n_r <= -n_r;
        end
      end
      DIV_ABS: begin
        nneg_r <= n_r[BIG_BITS-1];
        a_r    <= n_r[BIG_BITS-1] ? -n_r : n_r;
        q_r    <= '0;
        rem_r  <= 1'b0;
      end
      DIV_CHK: begin
        if (ovf) begin
          q_r <= QUO_BITS'(1) << (WORD_BITS + 1);
        end else begin
          ms_r <= m_r << WORD_BITS;
          i_r  <= CNT_BITS'(WORD_BITS);
        end
      end
      DIV_ITER: begin
        if ($unsigned(a_r) >= $unsigned(ms_r)) begin
          a_r      <= a_r - ms_r;
          q_r[i_r] <= 1'b1;
        end
        ms_r <= ms_r >> 1;
        i_r  <= i_r - CNT_BITS'(1);
      end
      DIV_REM: rem_r <= (a_r != '0);
      DIV_FIX: qs_r <= nneg_r ? (-qext - QS_BITS'(rem_r)) : qext;
      DIV_SUM: sum_r <= SUM_BITS'(base_r) + SUM_BITS'(qs_r);
      DIV_SAT: begin
        if (adj > SAT_HI) begin
          res_r <= SAT_HI[WORD_BITS-1:0];
        end else if (adj < SAT_LO) begin
          res_r <= SAT_LO[WORD_BITS-1:0];
        end else begin
          res_r <= adj[WORD_BITS-1:0];
        end
      end
      default: ;
    endcase
  end

  assign done   = done_r;
  assign result = res_r;

endmodule

`default_nettype wire

@@ design/smpf_back.sv @@
// ============================================================================
// smpf_back: parabola fit sequencer and result register
// Runs the three-column fit on a shared multiplier and divider and
// delivers result requests through an output register.
// ============================================================================
`default_nettype none

module smpf_back import smpf_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     job_valid,
  input  job_t     job,
  output logic     job_pop,
  output logic     out_valid,
  input  logic     out_ready,
  output fit_out_t out_result
);

  back_state_t state_r, state_nxt;
  fit_step_t   step_r, step_nxt;
  column_t     col_r, col_nxt;
  window_t     win_r;

  big_t d1_r, d3_r, d1s_r, d3s_r, dd_r, e1_r, e3_r;
  big_t pc_r, qc_r, p_r, q_r, ra_r, rb_r, rn_r, m2_r;

  word_t    held_e_r, held_d_r, held_v_r;
  status_t  held_st_r;
  fit_out_t out_r;
  logic     out_valid_r;

  logic  mul_start, mul_done, div_start, div_done;
  big_t  mul_a, mul_b, product, div_m;
  word_t div_res, y0, y1, y2;
  logic  out_free, degenerate, fit_done;

  smpf_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .op_a    (mul_a),
    .op_b    (mul_b),
    .done    (mul_done),
    .product (product)
  );

  smpf_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (div_start),
    .base   (y1),
    .num    (rn_r),
    .den    (div_m),
    .done   (div_done),
    .result (div_res)
  );

  always_comb begin
    unique case (col_r)
      COL_ENERGY:  {y2, y1, y0} = win_r.en;
      COL_DENSITY: {y2, y1, y0} = win_r.den;
      default:     {y2, y1, y0} = win_r.vac;
    endcase
  end

  assign out_free   = !out_valid_r || out_ready;
  assign degenerate = (dd_r == '0) || (pc_r == '0);
  assign fit_done   = (state_r == BK_CHECK && degenerate) ||
                      (state_r == BK_DIV_WAIT && div_done && col_r == COL_VACANCY);
  assign div_m      = (col_r == COL_ENERGY) ? rb_r : m2_r;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    col_nxt   = col_r;
    unique case (state_r)
      BK_IDLE: begin
        if (job_valid) begin
          state_nxt = job.do_fit ? BK_GEOM : BK_EMIT;
        end
      end
      BK_GEOM: begin
        state_nxt = BK_MUL_GO;
        step_nxt  = FS_T;
      end
      BK_COL: begin
        state_nxt = BK_MUL_GO;
        step_nxt  = FS_A;
      end
      BK_MUL_GO: state_nxt = BK_MUL_WAIT;
      BK_MUL_WAIT: begin
        if (mul_done) begin
          state_nxt = BK_MUL_GO;
          unique case (step_r)
            FS_T:   step_nxt = FS_DD;
            FS_DD:  step_nxt = FS_D1S;
            FS_D1S: step_nxt = FS_D3S;
            FS_D3S: begin
              state_nxt = BK_COL;
              col_nxt   = COL_ENERGY;
            end
            FS_A:   step_nxt = FS_B;
            FS_B:   step_nxt = FS_C;
            FS_C:   step_nxt = FS_D;
            FS_D: begin
              if (col_r == COL_ENERGY) begin
                state_nxt = BK_CHECK;
              end else begin
                step_nxt = FS_S1;
              end
            end
            FS_N:   step_nxt = FS_M;
            FS_M:   state_nxt = BK_DIV_GO;
            FS_PP:  step_nxt = FS_M2;
            FS_M2: begin
              state_nxt = BK_COL;
              col_nxt   = COL_DENSITY;
            end
            FS_S1:  step_nxt = FS_S2;
            FS_S2:  step_nxt = FS_SN;
            FS_SN:  state_nxt = BK_DIV_GO;
            default: state_nxt = BK_IDLE;
          endcase
        end
      end
      BK_CHECK: begin
        if (degenerate) begin
          state_nxt = job.do_out ? BK_EMIT : BK_IDLE;
        end else begin
          state_nxt = BK_MUL_GO;
          step_nxt  = FS_N;
        end
      end
      BK_DIV_GO: state_nxt = BK_DIV_WAIT;
      BK_DIV_WAIT: begin
        if (div_done) begin
          unique case (col_r)
            COL_ENERGY: begin
              state_nxt = BK_MUL_GO;
              step_nxt  = FS_PP;
            end
            COL_DENSITY: begin
              state_nxt = BK_COL;
              col_nxt   = COL_VACANCY;
            end
            default: state_nxt = job.do_out ? BK_EMIT : BK_IDLE;
          endcase
        end
      end
      BK_EMIT: if (out_free) state_nxt = BK_IDLE;
      default: state_nxt = BK_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    mul_start = (state_r == BK_MUL_GO);
    div_start = (state_r == BK_DIV_GO);
    job_pop   = (state_r == BK_EMIT && out_free) || (fit_done && !job.do_out);
    unique case (step_r)
      FS_T:    begin mul_a = d1_r; mul_b = d3_r;          end
      FS_DD:   begin mul_a = ra_r; mul_b = d1_r - d3_r;   end
      FS_D1S:  begin mul_a = d1_r; mul_b = d1_r;          end
      FS_D3S:  begin mul_a = d3_r; mul_b = d3_r;          end
      FS_A:    begin mul_a = e1_r; mul_b = d3_r;          end
      FS_B:    begin mul_a = e3_r; mul_b = d1_r;          end
      FS_C:    begin mul_a = e3_r; mul_b = d1s_r;         end
      FS_D:    begin mul_a = e1_r; mul_b = d3s_r;         end
      FS_N:    begin mul_a = q_r;  mul_b = q_r;           end
      FS_M:    begin mul_a = p_r;  mul_b = dd_r;          end
      FS_PP:   begin mul_a = p_r;  mul_b = p_r;           end
      FS_M2:   begin mul_a = ra_r; mul_b = dd_r;          end
      FS_S1:   begin mul_a = pc_r; mul_b = q_r;           end
      FS_S2:   begin mul_a = qc_r; mul_b = p_r;           end
      FS_SN:   begin mul_a = q_r;  mul_b = ra_r - (rb_r <<< 1); end
      default: begin mul_a = '0;   mul_b = '0;            end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      step_r      <= FS_T;
      col_r       <= COL_ENERGY;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      col_r   <= col_nxt;
      if (state_r == BK_EMIT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Fit datapath.
  always_ff @(posedge clk) begin
    if (state_r == BK_IDLE && job_valid && job.do_fit) begin
      win_r <= job.win;
    end
    if (state_r == BK_GEOM) begin
      d1_r <= widen(win_r.pos[0]) - widen(win_r.pos[1]);
      d3_r <= widen(win_r.pos[2]) - widen(win_r.pos[1]);
    end
    if (state_r == BK_COL) begin
      e1_r <= widen(y0) - widen(y1);
      e3_r <= widen(y2) - widen(y1);
    end
    if (state_r == BK_MUL_WAIT && mul_done) begin
      unique case (step_r)
        FS_T, FS_A, FS_C, FS_PP, FS_S1: ra_r <= product;
        FS_DD:  dd_r  <= product;
        FS_D1S: d1s_r <= product;
        FS_D3S: d3s_r <= product;
        FS_B:   pc_r  <= ra_r - product;
        FS_D:   qc_r  <= ra_r - product;
        FS_N:   rn_r  <= -product;
        FS_M:   rb_r  <= product <<< 2;
        FS_M2:  m2_r  <= product <<< 2;
        FS_S2:  rb_r  <= product;
        FS_SN:  rn_r  <= product;
        default: ;
      endcase
    end
    if (state_r == BK_CHECK) begin
      p_r <= pc_r;
      q_r <= qc_r;
      if (degenerate) begin
        held_e_r  <= '0;
        held_d_r  <= '0;
        held_v_r  <= '0;
        held_st_r <= ST_DEGENERATE;
      end else begin
        held_st_r <= ST_OK;
      end
    end
    if (state_r == BK_DIV_WAIT && div_done) begin
      unique case (col_r)
        COL_ENERGY:  held_e_r <= div_res;
        COL_DENSITY: held_d_r <= div_res;
        default:     held_v_r <= div_res;
      endcase
    end
    if (state_r == BK_EMIT && out_free) begin
      if (job.use_fit) begin
        out_r <= '{held_e_r, held_d_r, held_v_r, held_st_r};
      end else begin
        out_r <= '{'0, '0, '0, job.status};
      end
    end
  end

  assign out_valid  = out_valid_r;
  assign out_result = out_r;

endmodule

`default_nettype wire

@@ design/scan_minimum_parabolic_fit.sv @@
// ============================================================================
// scan_minimum_parabolic_fit: first interior energy minimum of a scan
// Finds where the energy of a scan stops falling and fits parabolas through
// the three rows around it to give the vertex energy, density and vacancy.
// ============================================================================
//
//   channel   ports                          moves
//   --------  -----------------------------  ---------------------------------
//   input     in_valid, in_ready, in_row     one scan row per request
//   output    out_valid, out_ready,          one result request per row
//             out_result                     marked last
//
// A row is taken while the job queue has room; the stop row queues a fit job
// and the last row a result job. A fit is twenty-six shift-add products and
// three divisions, or eight products when the window proves degenerate; each
// product stops early once the remaining multiplier bits are all zero.
// in_ready drops only while the queue is full, which a held result or a long fit
// causes. Reset is synchronous and active low and clears all control state.
//
// The front keeps the sliding window and the search flags; the back holds
// the job at the head of the queue until its fit and its result are done.
`default_nettype none

module scan_minimum_parabolic_fit import smpf_pkg::*; #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  row_in_t  in_row,
  output logic     out_valid,
  input  logic     out_ready,
  output fit_out_t out_result
);

  logic push, queue_full, pop, head_valid;
  job_t push_job, head;

  smpf_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_row     (in_row),
    .queue_full (queue_full),
    .push       (push),
    .push_job   (push_job)
  );

  smpf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_job   (push_job),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  smpf_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .job_valid  (head_valid),
    .job        (head),
    .job_pop    (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_result (out_result)
  );

endmodule

`default_nettype wire

@@ design/smpf_checker.sv @@
// ============================================================================
// smpf_checker: port-level checks for the scan minimum fit
// Watches the top-level ports and is bound to every instance of it.
// ============================================================================
`default_nettype none

module smpf_checker import smpf_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_ready,
  input row_in_t  in_row,
  input logic     out_valid,
  input logic     out_ready,
  input fit_out_t out_result
);

  // Scans whose last row was taken but whose result is not yet delivered.
  logic [3:0] pend_r;
  logic       last_acc, out_acc;

  assign last_acc = in_valid && in_ready && in_row.last;
  assign out_acc  = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else if (last_acc && !out_acc) begin
      pend_r <= pend_r + 4'd1;
    end else if (out_acc && !last_acc) begin
      pend_r <= pend_r - 4'd1;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result))
    else $error("result changed or dropped while stalled");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result.status != ST_OK |->
      out_result.energy_at_min == '0 && out_result.density_at_min == '0 &&
      out_result.vacancy_at_min == '0)
    else $error("error result carries nonzero values");

  a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != '0)
    else $error("result without a finished scan");

endmodule

bind scan_minimum_parabolic_fit smpf_checker u_smpf_checker (.*);

`default_nettype wire

@@ verif/fit_checker.sv @@
`timescale 1ns / 1ps
// ============================================================================
// fit_checker: scoreboard for the scan minimum parabolic fit
// Watches both channels, predicts the scan result from every accepted row
// and compares each accepted result with the oldest predicted one.
// ============================================================================
`default_nettype none

module fit_checker import smpf_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_ready,
  input  row_in_t  in_row,
  input  logic     out_valid,
  input  logic     out_ready,
  input  fit_out_t out_result,
  output int       errors,
  output int       pending,
  output int       results_seen
);

  // Exact width for every product of the fit.
  typedef logic signed [351:0] exact_t;

  word_t    win_pos [3];
  word_t    win_en  [3];
  word_t    win_den [3];
  word_t    win_vac [3];
  int       rows_in_scan;
  logic     stopped;
  fit_out_t held;
  fit_out_t expected_q [$];

  assign pending = expected_q.size();

  function automatic exact_t ext(word_t v);
    return exact_t'(v);
  endfunction

  // Truncation toward zero of base + num/den, saturated to a word.
  function automatic word_t vertex_value(word_t base, exact_t num, exact_t den);
    exact_t quo, sum;
    logic   inexact;
    if (den < 0) begin
      den = -den;
      num = -num;
    end
    quo     = num / den;
    inexact = (num % den) != 0;
    if (num < 0 && inexact) quo = quo - 1;
    sum = ext(base) + quo;
    if (sum < 0 && inexact) sum = sum + 1;
    if (sum > ext(32'sh7fffffff)) return 32'sh7fffffff;
    if (sum < ext(32'sh80000000)) return 32'sh80000000;
    return word_t'(sum);
  endfunction

  // Curvature and slope numerators of the parabola through one column.
  function automatic void parabola(input word_t y [3], input exact_t d1, input exact_t d3,
                                   output exact_t curv, output exact_t slope);
    exact_t e1, e3;
    e1    = ext(y[0]) - ext(y[1]);
    e3    = ext(y[2]) - ext(y[1]);
    curv  = e1 * d3 - e3 * d1;
    slope = e3 * d1 * d1 - e1 * d3 * d3;
  endfunction

  function automatic exact_t column_num(input word_t y [3], input exact_t d1,
                                        input exact_t d3, input exact_t p, input exact_t q);
    exact_t pc, qc;
    parabola(y, d1, d3, pc, qc);
    return q * (pc * q - exact_t'(2) * qc * p);
  endfunction

  task automatic fit_window();
    exact_t d1, d3, dd, p, q, m2;
    d1 = ext(win_pos[0]) - ext(win_pos[1]);
    d3 = ext(win_pos[2]) - ext(win_pos[1]);
    dd = d1 * d3 * (d1 - d3);
    parabola(win_en, d1, d3, p, q);
    held = '0;
    if (dd == 0 || p == 0) begin
      held.status = ST_DEGENERATE;
      return;
    end
    held.status = ST_OK;
    held.energy_at_min = vertex_value(win_en[1], -(q * q), exact_t'(4) * p * dd);
    m2 = exact_t'(4) * p * p * dd;
    held.density_at_min = vertex_value(win_den[1], column_num(win_den, d1, d3, p, q), m2);
    held.vacancy_at_min = vertex_value(win_vac[1], column_num(win_vac, d1, d3, p, q), m2);
  endtask

  task automatic clear_scan();
    for (int i = 0; i < 3; i++) begin
      win_pos[i] = '0;
      win_en[i]  = '0;
      win_den[i] = '0;
      win_vac[i] = '0;
    end
    rows_in_scan = 0;
    stopped      = 1'b0;
    held         = '0;
  endtask

  task automatic take_row(row_in_t r);
    fit_out_t res;
    if (!stopped) begin
      for (int i = 0; i < 2; i++) begin
        win_pos[i] = win_pos[i+1];
        win_en[i]  = win_en[i+1];
        win_den[i] = win_den[i+1];
        win_vac[i] = win_vac[i+1];
      end
      win_pos[2] = r.position;
      win_en[2]  = r.energy;
      win_den[2] = r.density;
      win_vac[2] = r.vacancy;
      if (rows_in_scan < 3) rows_in_scan++;
      if (rows_in_scan == 2 && win_en[1] < win_en[2]) begin
        stopped     = 1'b1;
        held        = '0;
        held.status = ST_RISES;
      end else if (rows_in_scan == 3 && !(win_en[2] < win_en[1])) begin
        fit_window();
        stopped = 1'b1;
      end
    end else if (rows_in_scan < 3) begin
      rows_in_scan++;
    end
    if (!r.last) return;
    res = '0;
    if (rows_in_scan < 3) res.status = ST_FEW_ROWS;
    else if (!stopped) res.status = ST_NO_MIN;
    else res = held;
    expected_q = {expected_q, res};
    clear_scan();
  endtask

  always @(posedge clk) begin
    fit_out_t want;
    if (!rst_n) begin
      clear_scan();
      expected_q.delete();
      errors       <= 0;
      results_seen <= 0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen <= results_seen + 1;
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result %h", $time, out_result);
          errors <= errors + 1;
        end else begin
          want = expected_q.pop_front();
          if (want !== out_result) begin
            $display("%0t: mismatch energy exp %h got %h, density exp %h got %h",
                     $time, want.energy_at_min, out_result.energy_at_min,
                     want.density_at_min, out_result.density_at_min);
            $display("%0t:          vacancy exp %h got %h, status exp %0d got %0d",
                     $time, want.vacancy_at_min, out_result.vacancy_at_min,
                     want.status, out_result.status);
            errors <= errors + 1;
          end
        end
      end
      if (in_valid && in_ready) take_row(in_row);
    end
  end

endmodule

`default_nettype wire

@@ verif/testbench.sv @@
`timescale 1ns / 1ps
// ============================================================================
// testbench: top of the scan minimum parabolic fit verification
// Drives directed and random scans into the block, stalls both channels at
// random, and reports the verdict from the checker's error count.
// ============================================================================
`default_nettype none

module testbench;
  import smpf_pkg::*;

  localparam int ROW_TARGET  = 1150;
  localparam int CYCLE_LIMIT = 8_000_000;
  localparam int QUIET_ROWS  = 150;   // rows at the end sent without idling
  localparam int HOLD_CYCLES = 20000; // the long output stall

  typedef enum int {
    SC_VALLEY, SC_NOISE, SC_SHORT, SC_RISE, SC_FALLING, SC_FLAT, SC_SAME_POS
  } scan_kind_t;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  row_in_t  in_row;
  logic     out_valid;
  logic     out_ready;
  fit_out_t out_result;

  int errors;
  int pending;
  int results_seen;
  int rows_sent;
  int scans_sent;
  int cycles;
  logic quiet;
  logic hold_done;

  scan_minimum_parabolic_fit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_row     (in_row),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_result (out_result)
  );

  fit_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_row       (in_row),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_result   (out_result),
    .errors       (errors),
    .pending      (pending),
    .results_seen (results_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: a correct run stays far below this even with every fit at
  // its slowest and the long output stall.
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("timeout after %0d cycles, %0d results pending", cycles, pending);
        $display("testbench: done, errors");
        $finish;
      end
    end
  end

  // Receiver: random bursts of ready and not ready, one long hold-off once
  // the run is under way so that the job queue fills and in_ready drops,
  // and a steady ready in the last part of the run.
  initial begin
    out_ready = 1'b0;
    hold_done = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!hold_done && rows_sent >= 300) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else if (quiet) begin
        out_ready <= 1'b1;
        @(posedge clk);
      end else if ($urandom_range(0, 3) == 0) begin
        out_ready <= 1'b1;
        repeat ($urandom_range(16, 64)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk);
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
    end
  end

  // Offer one request and hold it until the block takes it. in_ready is
  // read at the falling edge, where it is settled for the next rising one.
  task automatic send_row(row_in_t r);
    logic taken;
    in_row   <= r;
    in_valid <= 1'b1;
    do begin
      @(negedge clk);
      taken = in_ready;
      @(posedge clk);
    end while (!taken);
    rows_sent++;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  endtask

  function automatic word_t any_word();
    return word_t'($urandom);
  endfunction

  // Mostly values between -128 and 128 in Q16.16, now and then the full range.
  function automatic word_t column_value(logic wide);
    if (wide) return any_word();
    return word_t'($signed($urandom_range(0, 32'h00ff_ffff)) - 32'sh0080_0000);
  endfunction

  // Builds one scan of the given kind and sends its rows.
  task automatic run_scan(scan_kind_t kind);
    row_in_t rows [$];
    row_in_t r;
    int      len, turn;
    word_t   x, step, e;
    logic    wide;
    wide = ($urandom_range(0, 4) == 0);
    case (kind)
      SC_NOISE:   len = $urandom_range(1, 7);
      SC_SHORT:   len = $urandom_range(1, 2);
      SC_RISE:    len = $urandom_range(2, 6);
      SC_FALLING: len = $urandom_range(3, 8);
      default:    len = $urandom_range(3, 9);
    endcase
    turn = (len > 2) ? $urandom_range(1, len - 2) : 0;
    x    = column_value(wide);
    step = wide ? word_t'($urandom_range(1, 32'h3fff_ffff)) : word_t'($urandom_range(1, 1 << 18));
    e    = column_value(wide);
    for (int i = 0; i < len; i++) begin
      r          = '0;
      r.position = x + step * i;
      r.density  = column_value(wide);
      r.vacancy  = column_value(wide);
      r.last     = (i == len - 1);
      case (kind)
        SC_NOISE: begin
          r.position = any_word();
          r.energy   = any_word();
          r.density  = any_word();
          r.vacancy  = any_word();
        end
        SC_RISE: begin
          r.energy = (i == 1) ? e + word_t'($urandom_range(1, 1 << 20)) : e;
        end
        SC_FALLING: begin
          r.energy = e - word_t'(i * $urandom_range(1, 1 << 16));
        end
        SC_FLAT: begin
          // Level energy throughout: the third row is the stop row, and a window
          // with no curvature makes the fit degenerate.
          r.energy = e;
        end
        default: begin
          // A valley: energy falls up to the turn, then stops falling.
          if (i <= turn) e = (i == 0) ? e : e - word_t'($urandom_range(1, 1 << 20));
          else if (i == turn + 1) e = e + word_t'($urandom_range(0, 1 << 20));
          else e = column_value(1'b1);
          r.energy = e;
          if (kind == SC_SAME_POS && i == turn + 1) r.position = rows[i-1].position;
        end
      endcase
      rows.push_back(r);
    end
    foreach (rows[i]) send_row(rows[i]);
    scans_sent++;
  endtask

  // Directed valley with every column at a chosen value.
  task automatic send_fixed(word_t p0, word_t e0, word_t p1, word_t e1,
                            word_t p2, word_t e2, word_t v);
    row_in_t r;
    r = '{position: p0, energy: e0, density: v, vacancy: ~v, last: 1'b0};
    send_row(r);
    r = '{position: p1, energy: e1, density: ~v, vacancy: v, last: 1'b0};
    send_row(r);
    r = '{position: p2, energy: e2, density: v, vacancy: v, last: 1'b1};
    send_row(r);
    scans_sent++;
  endtask

  initial begin
    scan_kind_t kind;
    int         pick;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_row     = '0;
    quiet      = 1'b0;
    rows_sent  = 0;
    scans_sent = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: one scan of each status, the word extremes and fits
    // whose values at the vertex saturate.
    run_scan(SC_SHORT);
    run_scan(SC_RISE);
    run_scan(SC_FALLING);
    run_scan(SC_FLAT);
    run_scan(SC_SAME_POS);
    run_scan(SC_VALLEY);
    send_fixed(32'sh8000_0000, 32'sh7fff_ffff, 32'sh0000_0000, 32'sh8000_0000,
               32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh8000_0000);
    send_fixed(32'sh0000_0000, 32'sh0001_0000, 32'sh0000_0001, 32'sh0000_0000,
               32'sh0000_0003, 32'sh0000_0000, 32'sh7fff_ffff);
    send_fixed(32'sh0001_0000, 32'sh0002_0000, 32'sh0002_0000, 32'sh0001_0000,
               32'sh0003_0000, 32'sh0002_0000, 32'sh0000_0000);

    // Random part: mostly valleys with random content, the rest noise and
    // broken scans. The tail runs with no idling on either side.
    while (rows_sent < ROW_TARGET) begin
      if (rows_sent >= ROW_TARGET - QUIET_ROWS) quiet = 1'b1;
      pick = $urandom_range(0, 19);
      if (pick < 12) kind = SC_VALLEY;
      else if (pick < 14) kind = SC_NOISE;
      else if (pick < 15) kind = SC_SHORT;
      else if (pick < 16) kind = SC_RISE;
      else if (pick < 17) kind = SC_FALLING;
      else if (pick < 18) kind = SC_FLAT;
      else kind = SC_SAME_POS;
      run_scan(kind);
    end
    in_valid <= 1'b0;

    // Let the checker take the final row before looking at the backlog.
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);

    $display("summary: %0d rows in %0d scans, %0d results checked", rows_sent, scans_sent,
             results_seen);
    $display("summary: valleys, noise, short, rising, falling, flat and repeated-position scans");
    if (errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ scan_minimum_parabolic_fit.f @@
design/smpf_pkg.sv
design/smpf_front.sv
design/smpf_queue.sv
design/smpf_mul.sv
design/smpf_div.sv
design/smpf_back.sv
design/scan_minimum_parabolic_fit.sv
design/smpf_checker.sv
verif/fit_checker.sv
verif/testbench.sv
